### rtl/abr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alternate block reverser package
// Shared widths, command and release types, and register indexes.
// ----------------------------------------------------------------------------
package abr_pkg;

  localparam int ValueW        = 32;
  localparam int RevLenW       = 5;
  localparam int PassLenW      = 8;
  localparam int CfgIdxW       = 1;
  localparam int CfgDataW      = 8;
  localparam int MaxReverseDef = 16;
  localparam int MaxReverseLim = 64;
  localparam int CntLimW       = $clog2(MaxReverseLim + 1);

  localparam logic [RevLenW-1:0]  RevLenRst  = RevLenW'(3);
  localparam logic [PassLenW-1:0] PassLenRst = PassLenW'(2);

  typedef enum logic [CfgIdxW-1:0] {
    RegReverseLen = 1'b0,
    RegPassLen    = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    CmdPass  = 1'b0,
    CmdFlush = 1'b1
  } cmd_kind_e;

  typedef enum logic {
    BackIdle  = 1'b0,
    BackDrain = 1'b1
  } back_state_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [ValueW-1:0]   value;
    logic                bank;
    logic [CntLimW-1:0]  cnt;
    logic                last;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

### rtl/abr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module abr_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/abr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue of commands between the front and the back.
// ----------------------------------------------------------------------------
module abr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  abr_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output abr_pkg::cmd_t data_o,
  output logic          empty_o
);
  import abr_pkg::*;

  cmd_t       entry_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] fill_q, fill_d;
  logic       do_push, do_pop;

  assign full_o  = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    fill_d = fill_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> fill_q == 2'd2 && wptr_q == rptr_q)
    else $error("queue pointers disagree with fill level");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != 2'd3)
    else $error("queue fill level out of range");
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> wptr_q == rptr_q)
    else $error("queue empty with unequal pointers");
`endif

endmodule

### rtl/abr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Accepts input words, fills the stack banks and issues pass and flush
// commands to the back end.
// ----------------------------------------------------------------------------
module abr_front #(
  parameter int MAX_REVERSE = abr_pkg::MaxReverseDef,
  parameter int IdxW        = (MAX_REVERSE > 1) ? $clog2(MAX_REVERSE) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [abr_pkg::ValueW-1:0] value_i,
  input  logic                          stream_end_i,
  input  logic [abr_pkg::RevLenW-1:0]   reverse_len_i,
  input  logic [abr_pkg::PassLenW-1:0]  pass_len_i,
  output logic                          ram_we_o,
  output logic [IdxW:0]                 ram_waddr_o,
  output logic [abr_pkg::ValueW-1:0]    ram_wdata_o,
  output logic                          q_push_o,
  output abr_pkg::cmd_t                 q_data_o,
  input  logic                          q_full_i,
  input  abr_pkg::rel_t                 rel_i
);
  import abr_pkg::*;

  localparam int CntW = $clog2(MAX_REVERSE + 1);
  localparam int LenW = (CntW > RevLenW) ? CntW : RevLenW;

  logic                rev_phase_q, rev_phase_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [PassLenW-1:0] pass_cnt_q, pass_cnt_d;
  logic                bank_q, bank_d;
  logic [1:0]          busy_q, busy_d;

  logic                accept;
  logic [LenW-1:0]     rev_len_ext, max_ext, eff_rev, cnt_new;
  logic [PassLenW-1:0] eff_pass, pass_new;

  assign in_ready_o  = !q_full_i && (!rev_phase_q || !busy_q[bank_q]);
  assign accept      = in_valid_i && in_ready_o;
  assign ram_waddr_o = {bank_q, cnt_q[IdxW-1:0]};
  assign ram_wdata_o = value_i;

  always_comb begin
    rev_len_ext = LenW'(reverse_len_i);
    max_ext     = LenW'(MAX_REVERSE);
    if (rev_len_ext == '0) begin
      eff_rev = LenW'(1);
    end else if (rev_len_ext > max_ext) begin
      eff_rev = max_ext;
    end else begin
      eff_rev = rev_len_ext;
    end
    eff_pass = (pass_len_i == '0) ? PassLenW'(1) : pass_len_i;
    cnt_new  = LenW'(cnt_q) + LenW'(1);
    pass_new = pass_cnt_q + PassLenW'(1);
  end

  always_comb begin
    rev_phase_d    = rev_phase_q;
    cnt_d          = cnt_q;
    pass_cnt_d     = pass_cnt_q;
    bank_d         = bank_q;
    busy_d         = busy_q;
    ram_we_o       = 1'b0;
    q_push_o       = 1'b0;
    q_data_o.kind  = CmdPass;
    q_data_o.value = value_i;
    q_data_o.bank  = bank_q;
    q_data_o.cnt   = CntLimW'(cnt_new);
    q_data_o.last  = stream_end_i;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (accept) begin
      if (rev_phase_q) begin
        ram_we_o = 1'b1;
        if (cnt_new >= eff_rev || stream_end_i) begin
          q_push_o       = 1'b1;
          q_data_o.kind  = CmdFlush;
          busy_d[bank_q] = 1'b1;
          bank_d         = ~bank_q;
          cnt_d          = '0;
          pass_cnt_d     = '0;
          rev_phase_d    = stream_end_i;
        end else begin
          cnt_d = CntW'(cnt_new);
        end
      end else begin
        q_push_o = 1'b1;
        if (pass_new >= eff_pass || stream_end_i) begin
          rev_phase_d = 1'b1;
          pass_cnt_d  = '0;
        end else begin
          pass_cnt_d = pass_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rev_phase_q <= 1'b1;
      cnt_q       <= '0;
      pass_cnt_q  <= '0;
      bank_q      <= 1'b0;
      busy_q      <= 2'b00;
    end else begin
      rev_phase_q <= rev_phase_d;
      cnt_q       <= cnt_d;
      pass_cnt_q  <= pass_cnt_d;
      bank_q      <= bank_d;
      busy_q      <= busy_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_rel_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_i.valid |-> busy_q[rel_i.bank])
    else $error("release of a bank that was not handed over");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LenW'(cnt_q) < max_ext)
    else $error("stack count reached capacity without a flush");
  a_pass_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rev_phase_q |-> cnt_q == '0)
    else $error("stack not empty during the pass phase");
  a_flush_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push_o && q_data_o.kind == CmdFlush) |=> busy_q[$past(bank_q)])
    else $error("flushed bank not marked busy");
`endif

endmodule

### rtl/abr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Back end
// Executes queued commands: passes words through or drains a stack bank
// in reverse into the output register.
// ----------------------------------------------------------------------------
module abr_back #(
  parameter int MAX_REVERSE = abr_pkg::MaxReverseDef,
  parameter int IdxW        = (MAX_REVERSE > 1) ? $clog2(MAX_REVERSE) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  abr_pkg::cmd_t                     q_data_i,
  input  logic                              q_empty_i,
  output logic                              q_pop_o,
  output logic                              ram_re_o,
  output logic [IdxW:0]                     ram_raddr_o,
  input  logic [abr_pkg::ValueW-1:0]        ram_rdata_i,
  output abr_pkg::rel_t                     rel_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [abr_pkg::ValueW-1:0] value_res_o,
  output logic                              run_last_o,
  output logic                              stream_last_o
);
  import abr_pkg::*;

  back_state_e        state_q, state_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic               bank_q, bank_d;
  logic               last_q, last_d;
  logic               out_valid_q, out_valid_d;
  logic [ValueW-1:0]  val_q, val_d;
  logic               run_last_q, run_last_d;
  logic               stream_last_q, stream_last_d;
  logic               out_free;
  logic [CntLimW-1:0] cnt_m1;

  assign out_free = !out_valid_q || out_ready_i;
  assign cnt_m1   = q_data_i.cnt - CntLimW'(1);

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    bank_d        = bank_q;
    last_d        = last_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    val_d         = val_q;
    run_last_d    = run_last_q;
    stream_last_d = stream_last_q;
    q_pop_o       = 1'b0;
    ram_re_o      = 1'b0;
    ram_raddr_o   = {bank_q, idx_q};
    rel_o         = '0;
    unique case (state_q)
      BackIdle: begin
        if (!q_empty_i) begin
          if (q_data_i.kind == CmdPass) begin
            if (out_free) begin
              q_pop_o       = 1'b1;
              out_valid_d   = 1'b1;
              val_d         = q_data_i.value;
              run_last_d    = 1'b1;
              stream_last_d = q_data_i.last;
            end
          end else begin
            q_pop_o     = 1'b1;
            idx_d       = cnt_m1[IdxW-1:0];
            bank_d      = q_data_i.bank;
            last_d      = q_data_i.last;
            ram_re_o    = 1'b1;
            ram_raddr_o = {q_data_i.bank, cnt_m1[IdxW-1:0]};
            state_d     = BackDrain;
          end
        end
      end
      BackDrain: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          val_d         = ram_rdata_i;
          run_last_d    = (idx_q == '0);
          stream_last_d = last_q && (idx_q == '0);
          if (idx_q == '0) begin
            rel_o.valid = 1'b1;
            rel_o.bank  = bank_q;
            state_d     = BackIdle;
          end else begin
            idx_d       = idx_q - IdxW'(1);
            ram_re_o    = 1'b1;
            ram_raddr_o = {bank_q, idx_q - IdxW'(1)};
          end
        end
      end
      default: begin
        state_d = BackIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BackIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q         <= idx_d;
    bank_q        <= bank_d;
    last_q        <= last_d;
    val_q         <= val_d;
    run_last_q    <= run_last_d;
    stream_last_q <= stream_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign value_res_o   = val_q;
  assign run_last_o    = run_last_q;
  assign stream_last_o = stream_last_q;

`ifndef NO_ASSERTIONS
  a_rel_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_o.valid |-> state_q == BackDrain && idx_q == '0)
    else $error("bank released before the stack was drained");
  a_rel_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_o.valid |=> out_valid_o && run_last_o)
    else $error("drained run does not end with run_last");
  a_stream_last_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stream_last_o |-> run_last_o)
    else $error("stream end not at the end of a run");
`endif

endmodule

### rtl/alternate_block_reverser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alternate block reverser
// Reverses the first reverse_len words of each round and passes the next
// pass_len words through, marking run and stream ends.
// ----------------------------------------------------------------------------
// Words are accepted at up to one per cycle. Words of a reversed block go
// into one of two stack banks while the back end drains the other, so the
// front stalls only when both banks wait to be drained or the two-entry
// command queue is full. The back end emits up to one word per cycle while
// the output is taken: a passed word is registered once it reaches the
// queue head, and a reversed block is read from the stack word by word into
// the output register, limited by the single read port of the stack memory.
module alternate_block_reverser_top #(
  parameter int MAX_REVERSE = abr_pkg::MaxReverseDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [abr_pkg::ValueW-1:0]   value_i,
  input  logic                                stream_end_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [abr_pkg::ValueW-1:0]   value_res_o,
  output logic                                run_last_o,
  output logic                                stream_last_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [abr_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [abr_pkg::CfgDataW-1:0]        cfg_data_i
);
  import abr_pkg::*;

  localparam int IdxW     = (MAX_REVERSE > 1) ? $clog2(MAX_REVERSE) : 1;
  localparam int RamDepth = 2 * (2 ** IdxW);

  logic [RevLenW-1:0]  reverse_len_q;
  logic [PassLenW-1:0] pass_len_q;

  logic              ram_we, ram_re;
  logic [IdxW:0]     ram_waddr, ram_raddr;
  logic [ValueW-1:0] ram_wdata, ram_rdata;
  logic              q_push, q_pop, q_full, q_empty;
  cmd_t              q_wdata, q_rdata;
  rel_t              rel;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reverse_len_q <= RevLenRst;
      pass_len_q    <= PassLenRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegReverseLen: reverse_len_q <= cfg_data_i[RevLenW-1:0];
        RegPassLen:    pass_len_q    <= cfg_data_i[PassLenW-1:0];
        default:       ;
      endcase
    end
  end

  abr_front #(
    .MAX_REVERSE(MAX_REVERSE),
    .IdxW       (IdxW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .stream_end_i (stream_end_i),
    .reverse_len_i(reverse_len_q),
    .pass_len_i   (pass_len_q),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata),
    .q_full_i     (q_full),
    .rel_i        (rel)
  );

  abr_ram #(
    .Width(ValueW),
    .Depth(RamDepth)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  abr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  abr_back #(
    .MAX_REVERSE(MAX_REVERSE),
    .IdxW       (IdxW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_data_i     (q_rdata),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .rel_o        (rel),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_res_o  (value_res_o),
    .run_last_o   (run_last_o),
    .stream_last_o(stream_last_o)
  );

endmodule

### test/abr_reorder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alternate block reverser checker
// Watches the word, result and register channels of the reverser. It keeps
// its own copy of the registers, the block stack and the round state. It
// predicts the reordered words for every accepted input word and compares
// each accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
module abr_reorder_checker #(
  parameter int MAX_REVERSE = abr_pkg::MaxReverseDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic signed [abr_pkg::ValueW-1:0]   value_i,
  input  logic                                stream_end_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic signed [abr_pkg::ValueW-1:0]   value_res_i,
  input  logic                                run_last_i,
  input  logic                                stream_last_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [abr_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [abr_pkg::CfgDataW-1:0]        cfg_data_i,
  output int                                  mismatch_count_o,
  output int                                  words_pending_o
);

  typedef struct packed {
    logic signed [abr_pkg::ValueW-1:0] value;
    logic                              run_last;
    logic                              stream_last;
  } result_word_t;

  result_word_t                      expected_words[$];
  logic [abr_pkg::RevLenW-1:0]       reverse_len_q;
  logic [abr_pkg::PassLenW-1:0]      pass_len_q;
  logic signed [abr_pkg::ValueW-1:0] block_words[MAX_REVERSE];
  int unsigned                       stacked;
  logic                              reversing;
  logic [abr_pkg::PassLenW-1:0]      passed;

  task automatic reorder_word(input logic signed [abr_pkg::ValueW-1:0] word,
                              input logic last);
    int unsigned  block_len;
    int unsigned  pass_limit;
    result_word_t res;
    block_len  = (reverse_len_q == 0) ? 1 : reverse_len_q;
    if (block_len > MAX_REVERSE) block_len = MAX_REVERSE;
    pass_limit = (pass_len_q == 0) ? 1 : pass_len_q;
    if (reversing) begin
      if (stacked < MAX_REVERSE) begin
        block_words[stacked] = word;
        stacked++;
      end
      if (stacked >= block_len || last) begin
        while (stacked > 0) begin
          stacked--;
          res.value       = block_words[stacked];
          res.run_last    = (stacked == 0);
          res.stream_last = last && (stacked == 0);
          expected_words.push_back(res);
        end
        reversing = last;
        passed    = '0;
      end
    end else begin
      res.value       = word;
      res.run_last    = 1'b1;
      res.stream_last = last;
      expected_words.push_back(res);
      passed = passed + 1'b1;
      if (passed >= pass_limit || last) begin
        reversing = 1'b1;
        passed    = '0;
      end
    end
    if (last) begin
      stacked   = 0;
      passed    = '0;
      reversing = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_word_t exp_word;
    if (!rst_ni) begin
      expected_words.delete();
      reverse_len_q    = abr_pkg::RevLenRst;
      pass_len_q       = abr_pkg::PassLenRst;
      stacked          = 0;
      reversing        = 1'b1;
      passed           = '0;
      mismatch_count_o = 0;
      words_pending_o  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $error("value_res: expected no word, actual %0d", value_res_i);
          mismatch_count_o++;
        end else begin
          exp_word = expected_words.pop_front();
          if (value_res_i !== exp_word.value) begin
            $error("value_res: expected %0d, actual %0d", exp_word.value, value_res_i);
            mismatch_count_o++;
          end
          if (run_last_i !== exp_word.run_last) begin
            $error("run_last: expected %0b, actual %0b", exp_word.run_last, run_last_i);
            mismatch_count_o++;
          end
          if (stream_last_i !== exp_word.stream_last) begin
            $error("stream_last: expected %0b, actual %0b", exp_word.stream_last,
                   stream_last_i);
            mismatch_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          abr_pkg::RegReverseLen: reverse_len_q = cfg_data_i[abr_pkg::RevLenW-1:0];
          abr_pkg::RegPassLen:    pass_len_q    = cfg_data_i[abr_pkg::PassLenW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        reorder_word(value_i, stream_end_i);
      end
      words_pending_o = expected_words.size();
    end
  end

endmodule

### test/alternate_block_reverser_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alternate block reverser testbench
// Drives word streams and register writes into the reverser with random
// gaps on both sides, first a directed set of corner cases and then random
// phases under changing settings, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module alternate_block_reverser_top_test;

  localparam int SettleCycles  = 32;
  localparam int WatchdogLimit = 2000;
  localparam int RandomPhases  = 8;
  localparam int PhaseWords    = 50;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_ready;
  logic signed [abr_pkg::ValueW-1:0]    value;
  logic                                 stream_end;
  logic                                 out_valid;
  logic                                 out_ready;
  logic signed [abr_pkg::ValueW-1:0]    value_res;
  logic                                 run_last;
  logic                                 stream_last;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [abr_pkg::CfgIdxW-1:0]          cfg_index;
  logic [abr_pkg::CfgDataW-1:0]         cfg_data;
  logic                                 no_gaps;
  int                                   mismatch_count;
  int                                   words_pending;
  int                                   idle_cycles;

  alternate_block_reverser_top u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .value_i       (value),
    .stream_end_i  (stream_end),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .value_res_o   (value_res),
    .run_last_o    (run_last),
    .stream_last_o (stream_last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  abr_reorder_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .value_i          (value),
    .stream_end_i     (stream_end),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .value_res_i      (value_res),
    .run_last_i       (run_last),
    .stream_last_i    (stream_last),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .words_pending_o  (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WatchdogLimit) begin
      $display("FAIL alternate_block_reverser_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned wait_cycles;
    do @(negedge clk); while (!rst_n);
    forever begin
      wait_cycles = no_gaps ? 0 : $urandom_range(0, 11);
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  task automatic send_word(input logic signed [abr_pkg::ValueW-1:0] word, input logic last);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    value      <= word;
    stream_end <= last;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  task automatic send_stream(input int len, input logic close);
    for (int i = 0; i < len; i++) begin
      send_word($urandom, close && (i == len - 1));
    end
  endtask

  task automatic write_reg(input abr_pkg::cfg_reg_e idx,
                           input logic [abr_pkg::CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // A stream may stop mid-round without a result due, so the block is left to
  // settle after the last expected word has left before the next write.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (words_pending != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic random_phase(input int words, input logic close_last);
    int          left;
    int          len;
    int unsigned pick;
    logic        partial;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       write_reg(abr_pkg::RegReverseLen, 8'd0);
      1:       write_reg(abr_pkg::RegReverseLen, 8'd16);
      2:       write_reg(abr_pkg::RegReverseLen, 8'($urandom_range(17, 31)));
      3:       write_reg(abr_pkg::RegReverseLen, 8'd1);
      default: write_reg(abr_pkg::RegReverseLen, 8'($urandom_range(1, 16)));
    endcase
    pick = $urandom_range(0, 9);
    case (pick)
      0:       write_reg(abr_pkg::RegPassLen, 8'd0);
      1:       write_reg(abr_pkg::RegPassLen, 8'd255);
      2:       write_reg(abr_pkg::RegPassLen, 8'd1);
      3:       write_reg(abr_pkg::RegPassLen, 8'($urandom_range(9, 254)));
      default: write_reg(abr_pkg::RegPassLen, 8'($urandom_range(1, 8)));
    endcase
    no_gaps <= ($urandom_range(0, 3) == 0);
    partial = !close_last && ($urandom_range(0, 2) == 0);
    left    = words;
    while (left > 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) len = $urandom_range(1, 12);
      else if (pick < 9) len = $urandom_range(13, 24);
      else len = $urandom_range(25, 40);
      if (len > left) len = left;
      left -= len;
      send_stream(len, (left > 0) || !partial);
    end
    settle();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    value      = '0;
    stream_end = 1'b0;
    out_ready  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = abr_pkg::RegReverseLen;
    cfg_data   = '0;
    no_gaps    = 1'b0;
    idle_cycles = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: a full block, a passed word that ends the stream, and
    // a stream of one word.
    send_word(32'sh7FFF_FFFF, 1'b0);
    send_word(32'sh8000_0000, 1'b0);
    send_word(32'sh0000_0000, 1'b0);
    send_word(-32'sd1, 1'b1);
    send_word(32'sh5A5A_A5A5, 1'b1);
    settle();

    // Zero lengths act as one.
    write_reg(abr_pkg::RegReverseLen, 8'd0);
    write_reg(abr_pkg::RegPassLen, 8'd0);
    send_stream(3, 1'b1);
    settle();

    // A length above capacity, then both lengths lowered mid-round.
    write_reg(abr_pkg::RegReverseLen, 8'd20);
    write_reg(abr_pkg::RegPassLen, 8'd255);
    send_stream(10, 1'b0);
    settle();
    write_reg(abr_pkg::RegReverseLen, 8'd2);
    send_stream(3, 1'b0);
    settle();
    write_reg(abr_pkg::RegPassLen, 8'd1);
    send_word($urandom, 1'b0);
    send_word($urandom, 1'b1);
    settle();

    for (int p = 0; p < RandomPhases; p++) begin
      random_phase(PhaseWords, p == RandomPhases - 1);
    end

    if (mismatch_count == 0 && words_pending == 0) begin
      $display("PASS alternate_block_reverser_top");
    end else begin
      $display("FAIL alternate_block_reverser_top");
    end
    $finish;
  end

endmodule
